// ----- hw/rtl/lfu_cache_lru_tiebreak_macros.svh -----
// Assertion macros shared by the cache RTL.
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LFU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- hw/rtl/lfu_pkg.sv -----
// Shared types and constants for the LFU cache.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CNT_W = 16;
   localparam int CFG_W = 5;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;
   localparam logic [VAL_W-1:0] GET_MISS_VALUE = '1;
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef struct packed {
      logic       rsp_hit;
      logic [VAL_W-1:0] read_value;
      logic       evicted;
      logic [KEY_W-1:0] evicted_key;
   } rsp_type;
endpackage
`default_nettype wire

// ----- hw/rtl/lfu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                                          clock,
   input  wire                                          wr_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]                              wr_data,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/lfu_cache_lru_tiebreak.sv -----
// Top level of the LFU cache with least-recently-used tie break.
//
//  channel | dir | fields (low bit first)
//  req     | in  | tuser: req_type; tdata: key, value
//  rsp     | out | tuser: hit, evicted; tdata: read_value, evicted_key
//  csr     | in  | capacity_in_use
//
// A request runs a scan over the entry RAM for the key and the victim (one entry
// a cycle, through the registered RAM read) and, when an entry changes, a second
// pass that rewrites recency ranks one entry a cycle.
// The result is registered from the output state, after the decide state and the
// second pass if there is one; the next request can be taken in the cycle after.
// Reset is synchronous; valid bits live in flip-flops and clear at once.
// A result waits in the output register while the next request is processed; a
// finished request stalls only while that register is still full.
`timescale 1ns / 1ps
`default_nettype none
`include "lfu_cache_lru_tiebreak_macros.svh"
module lfu_cache_lru_tiebreak #(
   parameter int CAPACITY = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire [4:0]   csr_wr_data,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [63:0]  req_tdata,   // key[31:0], value[63:32]
   input  wire         req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // read_value[31:0], evicted_key[63:32]
   output logic [1:0]  rsp_tuser    // hit[0], evicted[1]
);
   import lfu_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RW = IW + 1;
   localparam int EW = KEY_W + VAL_W + CNT_W + RW;
   localparam int OW = $clog2(CAPACITY + 1);
   localparam int CW = (OW > CFG_W) ? OW : CFG_W;
   localparam int CAP_LIM = (CAPACITY < 31) ? CAPACITY : 31;
   localparam logic [CFG_W-1:0] CAP_MAX = CFG_W'(CAP_LIM);

   localparam logic [2:0] ST_IDLE = 3'd0, ST_SCAN = 3'd1, ST_DECIDE = 3'd2,
                          ST_FIX = 3'd3, ST_WRITE = 3'd4, ST_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CFG_W-1:0] cap_cfg_ff;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [RW:0] idx_ff, idx_in;
   logic is_put_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;
   logic found_ff, found_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic have_vic_ff, have_vic_in;
   logic [IW-1:0] vic_ff, vic_in;
   logic [CNT_W-1:0] vic_cnt_ff, vic_cnt_in;
   logic [RW-1:0] vic_rank_ff, vic_rank_in;
   logic [KEY_W-1:0] vic_key_ff, vic_key_in;
   logic have_free_ff, have_free_in;
   logic [IW-1:0] free_ff, free_in;
   logic [RW-1:0] hit_rank_ff, hit_rank_in;
   // fix pass: mode flags, target slot
   logic fix_bump_ff, fix_bump_in;
   logic fix_ins_ff, fix_ins_in;
   logic fix_evict_ff, fix_evict_in;
   logic [IW-1:0] tgt_ff, tgt_in;
   rsp_type rsp_ff, rsp_in;
   rsp_type out_ff, out_in;
   logic rsp_v_ff, rsp_v_in;

   logic wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [KEY_W-1:0] e_key;
   logic [VAL_W-1:0] e_val;
   logic [CNT_W-1:0] e_cnt;
   logic [RW-1:0] e_rank, new_rank;
   logic [CFG_W-1:0] cap;
   logic [IW-1:0] cur;
   logic cur_valid, rd_live;

   lfu_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   assign {e_key, e_val, e_cnt, e_rank} = rd_data;
   assign cap = (cap_cfg_ff > CAP_MAX) ? CAP_MAX : cap_cfg_ff;
   // entry delivered by the RAM this cycle was addressed in the cycle before
   assign cur = IW'(idx_ff - 1'b1);
   assign rd_live = (idx_ff != '0) && (idx_ff <= (RW+1)'(CAPACITY));
   assign cur_valid = rd_live && valid_ff[cur];
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff; valid_in = valid_ff; occ_in = occ_ff; idx_in = idx_ff;
      found_in = found_ff; slot_in = slot_ff; have_vic_in = have_vic_ff;
      vic_in = vic_ff; vic_cnt_in = vic_cnt_ff; vic_rank_in = vic_rank_ff;
      vic_key_in = vic_key_ff; have_free_in = have_free_ff; free_in = free_ff;
      hit_rank_in = hit_rank_ff;
      fix_bump_in = fix_bump_ff; fix_ins_in = fix_ins_ff; fix_evict_in = fix_evict_ff;
      tgt_in = tgt_ff; rsp_in = rsp_ff; out_in = out_ff; rsp_v_in = rsp_v_ff;
      wr_en = 1'b0; wr_addr = cur; wr_data = rd_data;
      rd_addr = (idx_ff < (RW+1)'(CAPACITY)) ? IW'(idx_ff) : '0;
      new_rank = e_rank;
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               state_in = ST_SCAN; idx_in = '0; found_in = 1'b0;
               have_vic_in = 1'b0; have_free_in = 1'b0;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (cur_valid) begin
               if (e_key == key_ff && !found_ff) begin
                  found_in = 1'b1; slot_in = cur; hit_rank_in = e_rank;
               end
               if (!have_vic_ff || e_cnt < vic_cnt_ff ||
                   (e_cnt == vic_cnt_ff && e_rank > vic_rank_ff)) begin
                  have_vic_in = 1'b1; vic_in = cur; vic_cnt_in = e_cnt;
                  vic_rank_in = e_rank; vic_key_in = e_key;
               end
            end else if (rd_live && !have_free_ff) begin
               have_free_in = 1'b1; free_in = cur;
            end
            if (idx_ff == (RW+1)'(CAPACITY)) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            rsp_in = '0;
            rsp_in.rsp_hit = found_ff;
            fix_bump_in = 1'b0; fix_ins_in = 1'b0; fix_evict_in = 1'b0;
            idx_in = '0;
            state_in = ST_OUT;
            if (!is_put_ff) begin
               if (found_ff) begin
                  rsp_in.read_value = 'x;
                  fix_bump_in = 1'b1; tgt_in = slot_ff; state_in = ST_FIX;
               end else begin
                  rsp_in.read_value = GET_MISS_VALUE;
               end
            end else if (cap != '0) begin
               if (found_ff) begin
                  fix_bump_in = 1'b1; tgt_in = slot_ff; state_in = ST_FIX;
               end else if (CW'(occ_ff) >= CW'(cap) && have_vic_ff) begin
                  rsp_in.evicted = 1'b1; rsp_in.evicted_key = vic_key_ff;
                  fix_evict_in = 1'b1; fix_ins_in = 1'b1; tgt_in = vic_ff;
                  state_in = ST_FIX;
               end else if (have_free_ff) begin
                  fix_ins_in = 1'b1; tgt_in = free_ff; state_in = ST_FIX;
               end
            end
         end
         ST_FIX: begin
            // second pass: age ranks and rewrite the touched entry
            idx_in = idx_ff + 1'b1;
            if (rd_live && (valid_ff[cur] || cur == tgt_ff)) begin
               wr_en = 1'b1;
               if (cur == tgt_ff) begin
                  if (fix_bump_ff) begin
                     if (!is_put_ff) rsp_in.read_value = e_val;
                     wr_data = {e_key, is_put_ff ? val_ff : e_val,
                                (e_cnt == COUNT_MAX) ? e_cnt : e_cnt + 1'b1, RW'(0)};
                  end else begin
                     wr_data = {key_ff, val_ff, CNT_W'(1), RW'(0)};
                  end
               end else begin
                  if (fix_bump_ff) begin
                     if (e_rank < hit_rank_ff) new_rank = e_rank + 1'b1;
                  end else begin
                     if (fix_evict_ff && e_rank > vic_rank_ff) new_rank = e_rank - 1'b1;
                     new_rank = new_rank + 1'b1;
                  end
                  wr_data = {e_key, e_val, e_cnt, new_rank};
               end
            end
            if (idx_ff == (RW+1)'(CAPACITY)) begin
               state_in = ST_OUT;
               if (fix_ins_ff) begin
                  valid_in[tgt_ff] = 1'b1;
                  if (!fix_evict_ff) occ_in = occ_ff + 1'b1;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in = 1'b1; out_in = rsp_ff; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; cap_cfg_ff <= CFG_W'(16); valid_ff <= '0;
         occ_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; occ_ff <= occ_in;
         rsp_v_ff <= rsp_v_in;
         if (csr_wr_en) cap_cfg_ff <= csr_wr_data;
      end
      if (req_tvalid && req_tready) begin
         is_put_ff <= req_tuser; key_ff <= req_tdata[31:0]; val_ff <= req_tdata[63:32];
      end
      idx_ff <= idx_in; found_ff <= found_in; slot_ff <= slot_in;
      have_vic_ff <= have_vic_in; vic_ff <= vic_in; vic_cnt_ff <= vic_cnt_in;
      vic_rank_ff <= vic_rank_in; vic_key_ff <= vic_key_in;
      have_free_ff <= have_free_in; free_ff <= free_in;
      hit_rank_ff <= hit_rank_in;
      fix_bump_ff <= fix_bump_in; fix_ins_ff <= fix_ins_in; fix_evict_ff <= fix_evict_in;
      tgt_ff <= tgt_in; rsp_ff <= rsp_in; out_ff <= out_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = {out_ff.evicted_key, out_ff.read_value};
   assign rsp_tuser = {out_ff.evicted, out_ff.rsp_hit};

   `LFU_ASSERT_IMP(a_ready_idle, clock, reset, req_tready, state_ff == ST_IDLE,
      "request taken outside idle")
   `LFU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_v_ff && !rsp_tready,
      rsp_v_ff && $stable(out_ff), "pending response changed")
   `LFU_ASSERT_IMP(a_occ_bound, clock, reset, 1'b1, occ_ff <= OW'(CAPACITY),
      "occupancy above capacity")
   `LFU_ASSERT_IMP(a_evict_put, clock, reset, rsp_v_ff && out_ff.evicted,
      !out_ff.rsp_hit, "eviction reported on a hit")
endmodule
`default_nettype wire

// ----- test/lfu_cache_lru_tiebreak_checker.sv -----
// Checker for the LFU cache: predicts each response from the accepted requests and compares it.
`timescale 1ns / 1ps
module lfu_cache_lru_tiebreak_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_wr_en,
   input  wire [4:0]  csr_wr_data,
   input  wire        req_tvalid,
   input  wire        req_tready,
   input  wire [63:0] req_tdata,
   input  wire        req_tuser,
   input  wire        rsp_tvalid,
   input  wire        rsp_tready,
   input  wire [63:0] rsp_tdata,
   input  wire [1:0]  rsp_tuser,
   output int         fail_count,
   output int         pending
);
   import lfu_pkg::*;

   localparam int SLOTS = 16;

   typedef struct {
      logic       hit;
      logic [31:0] read_value;
      logic       evicted;
      logic [31:0] evicted_key;
   } cache_rsp_type;

   logic [4:0]  capacity_reg;
   logic        slot_valid [SLOTS];
   logic [31:0] slot_key [SLOTS];
   logic [31:0] slot_value [SLOTS];
   logic [15:0] slot_count [SLOTS];
   logic [4:0]  slot_rank [SLOTS];
   int          fill;
   cache_rsp_type rsp_queue [$];

   assign pending = rsp_queue.size();

   function automatic void touch_slot(int s);
      logic [4:0] old_rank;
      old_rank = slot_rank[s];
      if (slot_count[s] != COUNT_MAX) slot_count[s]++;
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
      slot_rank[s] = 0;
   endfunction

   function automatic cache_rsp_type serve_request(logic is_put, logic [31:0] k,
                                                   logic [31:0] v);
      cache_rsp_type r;
      int cap, slot, victim;
      bit found;
      r = '{1'b0, 32'd0, 1'b0, 32'd0};
      cap = (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
      slot = -1;
      for (int i = 0; i < SLOTS; i++)
         if (slot == -1 && slot_valid[i] && slot_key[i] == k) slot = i;
      found = (slot != -1);
      r.hit = found;
      if (is_put == REQ_GET) begin
         if (found) begin
            r.read_value = slot_value[slot];
            touch_slot(slot);
         end else begin
            r.read_value = GET_MISS_VALUE;
         end
      end else if (cap == 0) begin
         // Puts are ignored while the capacity is zero.
      end else if (found) begin
         slot_value[slot] = v;
         touch_slot(slot);
      end else begin
         if (fill >= cap) begin
            victim = -1;
            for (int i = 0; i < SLOTS; i++)
               if (slot_valid[i] && (victim == -1 || slot_count[i] < slot_count[victim] ||
                   (slot_count[i] == slot_count[victim] &&
                    slot_rank[i] > slot_rank[victim])))
                  victim = i;
            if (victim != -1) begin
               r.evicted = 1'b1;
               r.evicted_key = slot_key[victim];
               slot_valid[victim] = 1'b0;
               for (int i = 0; i < SLOTS; i++)
                  if (slot_valid[i] && slot_rank[i] > slot_rank[victim]) slot_rank[i]--;
               fill--;
            end
         end
         slot = -1;
         for (int i = 0; i < SLOTS; i++)
            if (slot == -1 && !slot_valid[i]) slot = i;
         if (slot != -1) begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_valid[i]) slot_rank[i]++;
            slot_valid[slot] = 1'b1;
            slot_key[slot] = k;
            slot_value[slot] = v;
            slot_count[slot] = 1;
            slot_rank[slot] = 0;
            fill++;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cache_rsp_type want;
      if (reset) begin
         capacity_reg <= 5'd16;
         fill = 0;
         for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
         rsp_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) capacity_reg <= csr_wr_data;
         if (req_tvalid && req_tready)
            rsp_queue.push_back(serve_request(req_tuser, req_tdata[31:0], req_tdata[63:32]));
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_queue.size() == 0) begin
               $error("response with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = rsp_queue.pop_front();
               if (rsp_tuser[0] !== want.hit || rsp_tdata[31:0] !== want.read_value ||
                   rsp_tuser[1] !== want.evicted || rsp_tdata[63:32] !== want.evicted_key)
                  fail_count <= fail_count + 1;
               if (rsp_tuser[0] !== want.hit)
                  $error("hit: expected %0d, got %0d", want.hit, rsp_tuser[0]);
               if (rsp_tdata[31:0] !== want.read_value)
                  $error("read_value: expected %h, got %h", want.read_value, rsp_tdata[31:0]);
               if (rsp_tuser[1] !== want.evicted)
                  $error("evicted: expected %0d, got %0d", want.evicted, rsp_tuser[1]);
               if (rsp_tdata[63:32] !== want.evicted_key)
                  $error("evicted_key: expected %h, got %h", want.evicted_key,
                         rsp_tdata[63:32]);
            end
         end
      end
   end
endmodule

// ----- test/lfu_cache_lru_tiebreak_tb.sv -----
// Testbench top for the LFU cache: clock, reset, stimulus phases and the verdict.
`timescale 1ns / 1ps
module lfu_cache_lru_tiebreak_tb;
   import lfu_pkg::*;

   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [4:0]  csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          burst_left = 0;
   logic [31:0] key_pool [8];

   always #5 clock = ~clock;

   lfu_cache_lru_tiebreak dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   lfu_cache_lru_tiebreak_checker checker_inst (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .fail_count(fail_count),
      .pending(pending)
   );

   // The receiver stalls in runs: sometimes always ready, sometimes often stalled.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (reset) rsp_tready <= 1'b0;
      else if (cycle_count[9]) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // Within a burst tvalid stays high from one request to the next.
   task automatic send_request(logic is_put, logic [31:0] k, logic [31:0] v);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 6);
         gap = $urandom_range(0, 40);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= is_put;
      req_tdata <= {v, k};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_capacity(logic [4:0] cap);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(int count);
      logic [31:0] k;
      for (int n = 0; n < count; n++) begin
         // Mostly a small key set so hits, count ties and evictions are frequent.
         if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, 7)] + $urandom_range(0, 3);
         else k = $urandom;
         send_request($urandom_range(0, 1), k, $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFC;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: get miss on empty cache, fill past capacity, repeated hits, ties.
      send_request(REQ_GET, 32'h0, 32'h0);
      for (int i = 0; i < 17; i++) send_request(REQ_PUT, 32'h8000_0000 + i, 32'hFFFF_FFFF - i);
      send_request(REQ_GET, 32'h8000_0005, 32'h0);
      send_request(REQ_PUT, 32'h8000_0006, 32'h7FFF_FFFF);
      send_request(REQ_GET, 32'h8000_0006, 32'hFFFF_FFFF);
      send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0);

      write_capacity(5'd0);
      send_request(REQ_PUT, 32'h8000_0006, 32'h1234_5678);
      send_request(REQ_PUT, 32'h0000_1111, 32'h1);
      send_request(REQ_GET, 32'h8000_0006, 32'h0);

      write_capacity(5'd3); // lowered below occupancy
      random_phase(150);
      write_capacity(5'd31); // above the slot count
      random_phase(200);
      write_capacity(5'd1);
      random_phase(120);
      write_capacity(5'd0);
      random_phase(40);
      write_capacity(5'd16);
      random_phase(200);
      write_capacity(5'($urandom_range(2, 15)));
      random_phase(140);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_ram.sv
hw/rtl/lfu_cache_lru_tiebreak.sv
test/lfu_cache_lru_tiebreak_checker.sv
test/lfu_cache_lru_tiebreak_tb.sv
